>>> rtl/bffa_pkg.sv
// Shared widths, codes and controller/datapath interface types of the allocator.
package bffa_pkg;

   localparam int OFS_W        = 21;
   localparam int SIZE_W       = 22;
   localparam int STATUS_W     = 3;
   localparam int REQ_TDATA_W  = 48;
   localparam int RSP_TDATA_W  = 24;

   localparam int POOL_BYTES_DEF   = 2 * 1024 * 1024;
   localparam int HEADER_BYTES_DEF = 64;
   localparam int FREE_ENTRIES_DEF = 64;

   typedef enum logic [STATUS_W-1:0] {
      ST_FROM_LIST  = 3'd0,
      ST_BUMPED     = 3'd1,
      ST_EXHAUSTED  = 3'd2,
      ST_FREED      = 3'd3,
      ST_FREE_RANGE = 3'd4,
      ST_FREE_FULL  = 3'd5
   } rsp_status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DISPATCH,
      S_SCAN,
      S_SHIFT_PRIME,
      S_SHIFT,
      S_BUMP,
      S_DONE
   } state_type;

   typedef struct packed {
      logic load;
      logic free_do;
      logic scan_start;
      logic scan_step;
      logic take_hit;
      logic shift_start;
      logic shift_step;
      logic bump_do;
      logic rsp_load;
   } dp_cmd_type;

   typedef struct packed {
      logic is_free;
      logic count_zero;
      logic hit;
      logic ptr_zero;
      logic shift_need;
      logic shift_last;
      logic rsp_free;
   } dp_stat_type;

endpackage

>>> rtl/bffa_ctrl.sv
// Controller state machine that sequences dispatch, scan, shift, bump and response.
module bffa_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  bffa_pkg::dp_stat_type stat,
   output bffa_pkg::dp_cmd_type  cmd
);

   bffa_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bffa_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bffa_pkg::S_IDLE: begin
            if (req_tvalid) begin
               state_in = bffa_pkg::S_DISPATCH;
            end
         end
         bffa_pkg::S_DISPATCH: begin
            if (stat.is_free) begin
               state_in = bffa_pkg::S_DONE;
            end else if (stat.count_zero) begin
               state_in = bffa_pkg::S_BUMP;
            end else begin
               state_in = bffa_pkg::S_SCAN;
            end
         end
         bffa_pkg::S_SCAN: begin
            if (stat.hit) begin
               state_in = bffa_pkg::S_SHIFT_PRIME;
            end else if (stat.ptr_zero) begin
               state_in = bffa_pkg::S_BUMP;
            end
         end
         bffa_pkg::S_SHIFT_PRIME: begin
            if (stat.shift_need) begin
               state_in = bffa_pkg::S_SHIFT;
            end else begin
               state_in = bffa_pkg::S_DONE;
            end
         end
         bffa_pkg::S_SHIFT: begin
            if (stat.shift_last) begin
               state_in = bffa_pkg::S_DONE;
            end
         end
         bffa_pkg::S_BUMP: begin
            state_in = bffa_pkg::S_DONE;
         end
         bffa_pkg::S_DONE: begin
            if (stat.rsp_free) begin
               state_in = bffa_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = bffa_pkg::S_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         bffa_pkg::S_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         bffa_pkg::S_DISPATCH: begin
            cmd.free_do    = stat.is_free;
            cmd.scan_start = !stat.is_free && !stat.count_zero;
         end
         bffa_pkg::S_SCAN: begin
            cmd.take_hit  = stat.hit;
            cmd.scan_step = !stat.hit && !stat.ptr_zero;
         end
         bffa_pkg::S_SHIFT_PRIME: begin
            cmd.shift_start = stat.shift_need;
         end
         bffa_pkg::S_SHIFT: begin
            cmd.shift_step = 1'b1;
         end
         bffa_pkg::S_BUMP: begin
            cmd.bump_do = 1'b1;
         end
         bffa_pkg::S_DONE: begin
            cmd.rsp_load = stat.rsp_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

>>> rtl/bffa_dp.sv
// Datapath: request registers, free table memory, bump pointer and response register.
module bffa_dp #(
   parameter int POOL_BYTES   = bffa_pkg::POOL_BYTES_DEF,
   parameter int HEADER_BYTES = bffa_pkg::HEADER_BYTES_DEF,
   parameter int FREE_ENTRIES = bffa_pkg::FREE_ENTRIES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_kind,
   input  logic [bffa_pkg::SIZE_W-1:0]   in_bytes,
   input  logic [bffa_pkg::OFS_W-1:0]    in_offset,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [bffa_pkg::STATUS_W-1:0] out_status,
   output logic [bffa_pkg::OFS_W-1:0]    out_grant,
   input  bffa_pkg::dp_cmd_type          cmd,
   output bffa_pkg::dp_stat_type         stat
);

   localparam int OW    = bffa_pkg::OFS_W;
   localparam int SW    = bffa_pkg::SIZE_W;
   localparam int ENT_W = OW + SW;
   localparam int IDX_W = $clog2(FREE_ENTRIES);
   localparam int CNT_W = $clog2(FREE_ENTRIES + 1);

   localparam logic [SW-1:0]    POOL_LIM  = SW'(POOL_BYTES);
   localparam logic [SW:0]      POOL_END  = (SW + 1)'(POOL_BYTES);
   localparam logic [SW-1:0]    HDR_LIM   = SW'(HEADER_BYTES);
   localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(FREE_ENTRIES);
   localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);
   localparam logic [IDX_W-1:0] IDX_ONE   = IDX_W'(1);
   localparam logic [IDX_W-1:0] IDX_TWO   = IDX_W'(2);

   // Free table, oldest entry at index zero; each entry is {size, offset}.
   logic [ENT_W-1:0] free_tab_ff [FREE_ENTRIES];
   logic [ENT_W-1:0] rd_data_ff;

   logic                     kind_ff;
   logic [SW-1:0]            want_ff;
   logic [OW-1:0]            ofs_ff;
   logic [SW-1:0]            bump_ff, bump_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [IDX_W-1:0]         ptr_ff, ptr_in;
   logic [bffa_pkg::STATUS_W-1:0] status_ff, status_in;
   logic [OW-1:0]            grant_ff, grant_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [bffa_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [OW-1:0]            rsp_grant_ff;

   logic [IDX_W-1:0] rd_addr;
   logic [IDX_W-1:0] cnt_m1;
   logic [SW:0]      bump_sum;
   logic             bump_ok;
   logic             free_bad;
   logic             free_full;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [ENT_W-1:0] wr_data;
   logic [CNT_W-1:0] ptr_ext;

   assign cnt_m1    = IDX_W'(count_ff - CNT_ONE);
   assign ptr_ext   = CNT_W'(ptr_ff);
   assign bump_sum  = {1'b0, bump_ff} + {1'b0, want_ff};
   assign bump_ok   = (bump_ff < POOL_LIM) && (bump_sum <= POOL_END);
   assign free_bad  = ({1'b0, ofs_ff} < HDR_LIM) || ({1'b0, ofs_ff} >= POOL_LIM);
   assign free_full = (count_ff >= CNT_FULL);

   always_comb begin
      if (cmd.scan_start) begin
         rd_addr = cnt_m1;
      end else if (cmd.scan_step) begin
         rd_addr = ptr_ff - IDX_ONE;
      end else if (cmd.shift_start) begin
         rd_addr = ptr_ff + IDX_ONE;
      end else if (cmd.shift_step) begin
         rd_addr = ptr_ff + IDX_TWO;
      end else begin
         rd_addr = ptr_ff;
      end
   end

   // Writes come either from a free push at the tail or from closing the gap.
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = ptr_ff;
      wr_data = rd_data_ff;
      if (cmd.free_do && !free_bad && !free_full) begin
         wr_en   = 1'b1;
         wr_addr = IDX_W'(count_ff);
         wr_data = {want_ff, ofs_ff};
      end else if (cmd.shift_step) begin
         wr_en = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         free_tab_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= free_tab_ff[rd_addr];
   end

   always_comb begin
      bump_in   = bump_ff;
      count_in  = count_ff;
      ptr_in    = ptr_ff;
      status_in = status_ff;
      grant_in  = grant_ff;
      if (cmd.free_do) begin
         grant_in = '0;
         if (free_bad) begin
            status_in = bffa_pkg::ST_FREE_RANGE;
         end else if (free_full) begin
            status_in = bffa_pkg::ST_FREE_FULL;
         end else begin
            status_in = bffa_pkg::ST_FREED;
            count_in  = count_ff + CNT_ONE;
         end
      end
      if (cmd.scan_start) begin
         ptr_in = cnt_m1;
      end
      if (cmd.scan_step) begin
         ptr_in = ptr_ff - IDX_ONE;
      end
      if (cmd.take_hit) begin
         status_in = bffa_pkg::ST_FROM_LIST;
         grant_in  = rd_data_ff[OW-1:0];
         count_in  = count_ff - CNT_ONE;
      end
      if (cmd.shift_step) begin
         ptr_in = ptr_ff + IDX_ONE;
      end
      if (cmd.bump_do) begin
         if (bump_ok) begin
            status_in = bffa_pkg::ST_BUMPED;
            grant_in  = bump_ff[OW-1:0];
            bump_in   = bump_sum[SW-1:0];
         end else begin
            status_in = bffa_pkg::ST_EXHAUSTED;
            grant_in  = '0;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bump_ff      <= HDR_LIM;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         bump_ff      <= bump_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff <= in_kind;
         want_ff <= in_bytes;
         ofs_ff  <= in_offset;
      end
      ptr_ff    <= ptr_in;
      status_ff <= status_in;
      grant_ff  <= grant_in;
      if (cmd.rsp_load) begin
         rsp_status_ff <= status_ff;
         rsp_grant_ff  <= grant_ff;
      end
   end

   assign stat.is_free    = kind_ff;
   assign stat.count_zero = (count_ff == '0);
   assign stat.hit        = (rd_data_ff[ENT_W-1:OW] >= want_ff);
   assign stat.ptr_zero   = (ptr_ff == '0);
   assign stat.shift_need = (ptr_ext < count_ff);
   assign stat.shift_last = ((ptr_ext + CNT_ONE) == count_ff);
   assign stat.rsp_free   = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign out_status = rsp_status_ff;
   assign out_grant  = rsp_grant_ff;

endmodule

>>> rtl/bump_and_first_fit_allocator.sv
// Top level of the first-fit free list allocator with bump fallback.
//
// Hands out byte ranges of a pool whose first HEADER_BYTES bytes are reserved.
// An allocate scans the free table from the newest entry, takes the first
// entry that is large enough whole, and closes the gap so the order of the
// rest is kept; with no fit it bumps the next-free pointer or reports
// exhaustion. A free pushes the block as the newest entry, or is rejected when
// out of range or when the table is full. One item is worked on at a time. The
// time an allocate takes grows with the entries of the table that it reads and
// the entries that it moves behind its hit, since the single read port of the
// free table memory delivers one entry a cycle to both the scan and the gap
// closing. The next item can be accepted in the cycle after the result is
// loaded; a finished result waits in the output register while that item is
// accepted, and a result that is still held there stalls the following one.
module bump_and_first_fit_allocator #(
   parameter int POOL_BYTES   = bffa_pkg::POOL_BYTES_DEF,
   parameter int HEADER_BYTES = bffa_pkg::HEADER_BYTES_DEF,
   parameter int FREE_ENTRIES = bffa_pkg::FREE_ENTRIES_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // [21:0] req_bytes, [42:22] free_offset, [47:43] zero
   input  logic [bffa_pkg::REQ_TDATA_W-1:0] req_tdata,
   // [0] kind: 0 allocate, 1 free
   input  logic                             req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [20:0] granted_offset, [23:21] zero
   output logic [bffa_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // [2:0] status
   output logic [bffa_pkg::STATUS_W-1:0]    rsp_tuser
);

   localparam int OW = bffa_pkg::OFS_W;
   localparam int SW = bffa_pkg::SIZE_W;

   bffa_pkg::dp_cmd_type  cmd;
   bffa_pkg::dp_stat_type stat;
   logic [OW-1:0]         grant;

   bffa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   bffa_dp #(
      .POOL_BYTES   (POOL_BYTES),
      .HEADER_BYTES (HEADER_BYTES),
      .FREE_ENTRIES (FREE_ENTRIES)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .in_kind    (req_tuser),
      .in_bytes   (req_tdata[SW-1:0]),
      .in_offset  (req_tdata[SW+OW-1:SW]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .out_status (rsp_tuser),
      .out_grant  (grant),
      .cmd        (cmd),
      .stat       (stat)
   );

   assign rsp_tdata = {{(bffa_pkg::RSP_TDATA_W - OW){1'b0}}, grant};

endmodule
